### sv/pfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Program fetch line cache package
// Shared types, codes and constants of the fetch cache.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int unsigned LINE_BYTES_DEF  = 16;
  localparam int unsigned CACHE_BYTES_DEF = 512;

  localparam logic [7:0] RAM_BANK0        = 8'h70;
  localparam logic [7:0] RAM_BANK1        = 8'h71;
  localparam logic [7:0] MAX_ROM_BANK_RST = 8'd63;

  localparam int unsigned HIT_COST_FAST  = 1;
  localparam int unsigned HIT_COST_SLOW  = 2;
  localparam int unsigned BYTE_COST_FAST = 5;
  localparam int unsigned BYTE_COST_SLOW = 6;
  localparam int unsigned COST_MAX       = 127;

  typedef enum logic [1:0] {
    MODE_FETCH = 2'd0,
    MODE_REPLY = 2'd1,
    MODE_FLUSH = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_CACHED   = 2'd0,
    ST_UNCACHED = 2'd1,
    ST_LINE_REQ = 2'd2,
    ST_BYTE_REQ = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_LINE = 2'd1,
    PEND_BYTE = 2'd2
  } pend_e;

  typedef enum logic {
    CFG_FAST_CLOCK   = 1'b0,
    CFG_MAX_ROM_BANK = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] program_counter;
    logic [15:0] window_base;
    logic [7:0]  code_bank;
    logic [7:0]  mem_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  data_byte;
    logic        mem_source;
    logic [23:0] mem_address;
    logic [6:0]  cycle_cost;
  } out_item_t;

  // full line fill cost, saturated to the cost field
  function automatic logic [6:0] fill_cost(input int unsigned byte_cost,
                                           input int unsigned hit_cost,
                                           input int unsigned line_bytes);
    int unsigned c;
    c = byte_cost * line_bytes + hit_cost;
    if (c > COST_MAX) begin
      c = COST_MAX;
    end
    return c[6:0];
  endfunction

endpackage
`default_nettype wire

### sv/pfc_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fetch cache stream interface
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface pfc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/pfc_line_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fetch cache line RAM
// Byte-wide synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pfc_line_ram #(
  parameter int unsigned Depth = pfc_pkg::CACHE_BYTES_DEF,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [7:0]       wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### sv/program_fetch_line_cache_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Program fetch line cache
// Instruction fetch cache of CacheBytes bytes in lines of LineBytes bytes,
// with line fill and single byte requests towards ROM / RAM.
// ----------------------------------------------------------------------------
//
//  channel   dir  beat          notes
//  --------  ---  ------------  ------------------------------------------
//  in_i      in   in_item_t     fetch, memory data reply or flush
//  out_o     out  out_item_t    cached/uncached byte or memory request
//  cfg_*     in   index + data  fast_clock, max_rom_bank; write only
//
//  Rate: one beat per cycle while the output drains; a hit on a line filled
//  from memory holds input off for the registered read of the line RAM.
//  Reset clears the valid bits, the pending request and the control and
//  config registers at once; the line RAM is not cleared and needs no sweep.
//  Stalls: the output register takes a new result while the old one is
//  drained in the same cycle; input is held off only during a RAM read or
//  while an undrained result sits in the output register.
//
// ----------------------------------------------------------------------------
module program_fetch_line_cache_top #(
  parameter int unsigned LineBytes  = pfc_pkg::LINE_BYTES_DEF,
  parameter int unsigned CacheBytes = pfc_pkg::CACHE_BYTES_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pfc_stream_if.sink  in_i,
  pfc_stream_if.source out_o,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [7:0] cfg_data_i
);

  localparam int unsigned LbW      = $clog2(LineBytes);
  localparam int unsigned OffW     = $clog2(CacheBytes);
  localparam int unsigned NumLines = CacheBytes / LineBytes;
  localparam int unsigned LineW    = OffW - LbW;

  localparam logic [6:0] FillCostFast = pfc_pkg::fill_cost(pfc_pkg::BYTE_COST_FAST,
                                          pfc_pkg::HIT_COST_FAST, LineBytes);
  localparam logic [6:0] FillCostSlow = pfc_pkg::fill_cost(pfc_pkg::BYTE_COST_SLOW,
                                          pfc_pkg::HIT_COST_SLOW, LineBytes);

  // configuration
  logic       fast_q;
  logic [7:0] max_rom_q;

  // control state
  pfc_pkg::pend_e      pend_q, pend_d;
  logic [LbW-1:0]      cnt_q, cnt_d;        // bytes of the line received
  logic [OffW-1:0]     poff_q, poff_d;      // offset of the missed fetch
  logic [7:0]          hold_q, hold_d;      // missed byte, caught during fill
  logic [NumLines-1:0] valid_q, valid_d;
  logic [NumLines-1:0] zero_q, zero_d;      // line valid and all zero
  logic                rd_q, rd_d;          // RAM read in flight

  // output register
  logic               out_valid_q;
  pfc_pkg::out_item_t out_q, out_item_d;
  logic               out_load;

  // RAM ports
  logic            mem_we, mem_re;
  logic [OffW-1:0] mem_waddr;
  logic [7:0]      mem_rdata;

  // decode
  logic            in_ready, acc;
  logic [15:0]     off;
  logic            in_win, is_rom, is_ram, mapped;
  logic [7:0]      mbank;
  logic [LineW-1:0] line;
  logic [15:0]     dest;
  logic [23:0]     fill_addr;
  logic [6:0]      hit_cost, byte_cost, fill_cost;

  assign in_ready   = !rd_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = in_ready;
  assign acc        = in_i.valid && in_ready;

  assign off    = in_i.data.program_counter - in_i.data.window_base;
  assign in_win = (off[15:OffW] == '0);
  assign line   = off[OffW-1:LbW];
  assign dest   = {off[15:LbW], {LbW{1'b0}}};
  assign is_rom = (in_i.data.code_bank <= max_rom_q);
  assign is_ram = !is_rom && ((in_i.data.code_bank == pfc_pkg::RAM_BANK0) ||
                              (in_i.data.code_bank == pfc_pkg::RAM_BANK1));
  assign mapped = is_rom || is_ram;
  assign mbank  = is_rom ? in_i.data.code_bank :
                  (is_ram ? {7'd0, in_i.data.code_bank[0]} : 8'd0);
  assign fill_addr = {mbank, 16'h0000} + {8'h00, in_i.data.window_base} + {8'h00, dest};

  assign hit_cost  = fast_q ? 7'(pfc_pkg::HIT_COST_FAST)  : 7'(pfc_pkg::HIT_COST_SLOW);
  assign byte_cost = fast_q ? 7'(pfc_pkg::BYTE_COST_FAST) : 7'(pfc_pkg::BYTE_COST_SLOW);
  assign fill_cost = fast_q ? FillCostFast : FillCostSlow;

  assign mem_waddr = {poff_q[OffW-1:LbW], cnt_q};

  always_comb begin
    pend_d     = pend_q;
    cnt_d      = cnt_q;
    poff_d     = poff_q;
    hold_d     = hold_q;
    valid_d    = valid_q;
    zero_d     = zero_q;
    rd_d       = 1'b0;
    out_load   = 1'b0;
    out_item_d = '0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;

    if (rd_q) begin
      // hit data back from the line RAM
      out_load              = 1'b1;
      out_item_d.status     = pfc_pkg::ST_CACHED;
      out_item_d.data_byte  = mem_rdata;
      out_item_d.cycle_cost = hit_cost;
    end else if (acc) begin
      case (pfc_pkg::mode_e'(in_i.data.mode))
        pfc_pkg::MODE_FETCH: begin
          if (pend_q == pfc_pkg::PEND_NONE) begin
            if (in_win) begin
              if (valid_q[line]) begin
                if (zero_q[line]) begin
                  out_load              = 1'b1;
                  out_item_d.status     = pfc_pkg::ST_CACHED;
                  out_item_d.cycle_cost = hit_cost;
                end else begin
                  mem_re = 1'b1;
                  rd_d   = 1'b1;
                end
              end else if (mapped) begin
                pend_d                 = pfc_pkg::PEND_LINE;
                cnt_d                  = '0;
                poff_d                 = off[OffW-1:0];
                out_load               = 1'b1;
                out_item_d.status      = pfc_pkg::ST_LINE_REQ;
                out_item_d.mem_source  = is_ram;
                out_item_d.mem_address = fill_addr;
              end else begin
                // unmapped bank: line reads as zeros straight away
                valid_d[line]         = 1'b1;
                zero_d[line]          = 1'b1;
                out_load              = 1'b1;
                out_item_d.status     = pfc_pkg::ST_CACHED;
                out_item_d.cycle_cost = fill_cost;
              end
            end else if (mapped) begin
              pend_d                 = pfc_pkg::PEND_BYTE;
              out_load               = 1'b1;
              out_item_d.status      = pfc_pkg::ST_BYTE_REQ;
              out_item_d.mem_source  = is_ram;
              out_item_d.mem_address = {mbank, in_i.data.program_counter};
            end else begin
              out_load              = 1'b1;
              out_item_d.status     = pfc_pkg::ST_UNCACHED;
              out_item_d.cycle_cost = byte_cost;
            end
          end
        end
        pfc_pkg::MODE_REPLY: begin
          case (pend_q)
            pfc_pkg::PEND_BYTE: begin
              pend_d                = pfc_pkg::PEND_NONE;
              out_load              = 1'b1;
              out_item_d.status     = pfc_pkg::ST_UNCACHED;
              out_item_d.data_byte  = in_i.data.mem_data;
              out_item_d.cycle_cost = byte_cost;
            end
            pfc_pkg::PEND_LINE: begin
              mem_we = 1'b1;
              if (cnt_q == poff_q[LbW-1:0]) begin
                hold_d = in_i.data.mem_data;
              end
              if (cnt_q == {LbW{1'b1}}) begin
                valid_d[poff_q[OffW-1:LbW]] = 1'b1;
                zero_d[poff_q[OffW-1:LbW]]  = 1'b0;
                pend_d                      = pfc_pkg::PEND_NONE;
                cnt_d                       = '0;
                out_load                    = 1'b1;
                out_item_d.status           = pfc_pkg::ST_CACHED;
                out_item_d.data_byte        = (cnt_q == poff_q[LbW-1:0]) ?
                                              in_i.data.mem_data : hold_q;
                out_item_d.cycle_cost       = fill_cost;
              end else begin
                cnt_d = cnt_q + 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        pfc_pkg::MODE_FLUSH: begin
          valid_d = '0;
          zero_d  = '0;
          pend_d  = pfc_pkg::PEND_NONE;
          cnt_d   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  pfc_line_ram #(
    .Depth (CacheBytes),
    .AddrW (OffW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (in_i.data.mem_data),
    .re_i    (mem_re),
    .raddr_i (off[OffW-1:0]),
    .rdata_o (mem_rdata)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q    <= 1'b0;
      max_rom_q <= pfc_pkg::MAX_ROM_BANK_RST;
    end else if (cfg_we_i) begin
      case (pfc_pkg::cfg_idx_e'(cfg_idx_i))
        pfc_pkg::CFG_FAST_CLOCK:   fast_q    <= cfg_data_i[0];
        pfc_pkg::CFG_MAX_ROM_BANK: max_rom_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= pfc_pkg::PEND_NONE;
      cnt_q   <= '0;
      poff_q  <= '0;
      valid_q <= '0;
      zero_q  <= '0;
      rd_q    <= 1'b0;
    end else begin
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
      poff_q  <= poff_d;
      valid_q <= valid_d;
      zero_q  <= zero_d;
      rd_q    <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_item_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule
`default_nettype wire

### tb/sv/program_fetch_line_cache_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Program fetch line cache testbench
// Drives fetch, memory reply and flush beats with random gaps and output
// back-pressure. A scoreboard keeps its own copy of the cache lines, valid
// bits and pending request, works out the result of every accepted beat and
// compares each output beat field by field. The run goes through several
// register settings, the extremes among them.
// ----------------------------------------------------------------------------
module program_fetch_line_cache_top_tb;
  import pfc_pkg::*;

  localparam int unsigned LINE_B          = LINE_BYTES_DEF;
  localparam int unsigned CACHE_B         = CACHE_BYTES_DEF;
  localparam int unsigned N_LINES         = CACHE_B / LINE_B;
  localparam int unsigned ITEMS_PER_PHASE = 312;
  // cycles without a beat on either side before the run is given up
  localparam int unsigned STALL_LIMIT     = 5000;
  // settings per random phase: fast clock bit p, highest ROM bank in byte p
  localparam logic [5:0]  PH_FAST = 6'b010101;
  localparam logic [47:0] PH_ROM  = {8'd127, 8'h6F, 8'h70, 8'hFF, 8'h00, 8'd63};

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the cache state, queue of results still due
  // --------------------------------------------------------------------------
  class fetch_cache_sb;
    out_item_t   due_results[$];
    logic [7:0]  line_mem [CACHE_B];
    bit          line_ok  [N_LINES];
    pend_e       pend;
    int unsigned fill_cnt;
    int unsigned pend_off;
    bit          fast_clk;
    logic [7:0]  rom_top;
    int unsigned errors;

    function new();
      foreach (line_ok[i]) line_ok[i] = 1'b0;
      pend     = PEND_NONE;
      fill_cnt = 0;
      pend_off = 0;
      fast_clk = 1'b0;
      rom_top  = MAX_ROM_BANK_RST;
      errors   = 0;
    endfunction

    function void set_regs(logic fast, logic [7:0] top);
      fast_clk = fast;
      rom_top  = top;
    endfunction

    function logic [6:0] hit_cost();
      return 7'(fast_clk ? HIT_COST_FAST : HIT_COST_SLOW);
    endfunction

    function logic [6:0] byte_cost();
      return 7'(fast_clk ? BYTE_COST_FAST : BYTE_COST_SLOW);
    endfunction

    function logic [6:0] line_fill_cost();
      int unsigned c;
      c = (fast_clk ? BYTE_COST_FAST : BYTE_COST_SLOW) * LINE_B +
          (fast_clk ? HIT_COST_FAST : HIT_COST_SLOW);
      if (c > COST_MAX) c = COST_MAX;
      return 7'(c);
    endfunction

    function void queue_result(status_e st, logic [7:0] d, logic src,
                               logic [23:0] a, logic [6:0] c);
      out_item_t r;
      r.status      = st;
      r.data_byte   = d;
      r.mem_source  = src;
      r.mem_address = a;
      r.cycle_cost  = c;
      due_results.push_back(r);
    endfunction

    function void fetch(in_item_t it);
      logic [15:0] off;
      int unsigned line;
      bit          rom;
      bit          ram;
      logic [7:0]  mbank;
      logic [23:0] addr;
      off   = it.program_counter - it.window_base;
      rom   = (it.code_bank <= rom_top);
      ram   = !rom && (it.code_bank == RAM_BANK0 || it.code_bank == RAM_BANK1);
      mbank = rom ? it.code_bank : (ram ? it.code_bank - RAM_BANK0 : 8'h00);
      if (off < CACHE_B) begin
        line = off / LINE_B;
        if (line_ok[line]) begin
          queue_result(ST_CACHED, line_mem[off], 1'b0, 24'h0, hit_cost());
        end else if (rom || ram) begin
          pend     = PEND_LINE;
          fill_cnt = 0;
          pend_off = off;
          addr = {mbank, 16'h0000} + {8'h00, it.window_base} + 24'(line * LINE_B);
          queue_result(ST_LINE_REQ, 8'h00, ram, addr, 7'd0);
        end else begin
          // unmapped bank: line filled with zeros at once
          for (int k = 0; k < LINE_B; k++) line_mem[line * LINE_B + k] = 8'h00;
          line_ok[line] = 1'b1;
          queue_result(ST_CACHED, 8'h00, 1'b0, 24'h0, line_fill_cost());
        end
      end else if (rom || ram) begin
        pend = PEND_BYTE;
        queue_result(ST_BYTE_REQ, 8'h00, ram, {mbank, it.program_counter}, 7'd0);
      end else begin
        queue_result(ST_UNCACHED, 8'h00, 1'b0, 24'h0, byte_cost());
      end
    endfunction

    function void reply(logic [7:0] d);
      int unsigned line;
      if (pend == PEND_BYTE) begin
        pend = PEND_NONE;
        queue_result(ST_UNCACHED, d, 1'b0, 24'h0, byte_cost());
        return;
      end
      line = pend_off / LINE_B;
      line_mem[line * LINE_B + fill_cnt] = d;
      fill_cnt++;
      if (fill_cnt >= LINE_B) begin
        line_ok[line] = 1'b1;
        pend          = PEND_NONE;
        fill_cnt      = 0;
        queue_result(ST_CACHED, line_mem[pend_off], 1'b0, 24'h0, line_fill_cost());
      end
    endfunction

    // returns 1 when the beat changed state or produced a result
    function bit take_input(in_item_t it);
      case (it.mode)
        MODE_FETCH: begin
          if (pend != PEND_NONE) return 1'b0;
          fetch(it);
          return 1'b1;
        end
        MODE_REPLY: begin
          if (pend == PEND_NONE) return 1'b0;
          reply(it.mem_data);
          return 1'b1;
        end
        MODE_FLUSH: begin
          foreach (line_ok[i]) line_ok[i] = 1'b0;
          pend     = PEND_NONE;
          fill_cnt = 0;
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result beat with none due, status %0d data %02h",
                         got.status, got.data_byte));
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.data_byte !== want.data_byte)
        report($sformatf("data_byte %02h, want %02h", got.data_byte, want.data_byte));
      if (got.mem_source !== want.mem_source)
        report($sformatf("mem_source %0d, want %0d", got.mem_source, want.mem_source));
      if (got.mem_address !== want.mem_address)
        report($sformatf("mem_address %06h, want %06h", got.mem_address,
                         want.mem_address));
      if (got.cycle_cost !== want.cycle_cost)
        report($sformatf("cycle_cost %0d, want %0d", got.cycle_cost, want.cycle_cost));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  logic [7:0] cfg_data_i;

  pfc_stream_if #(.T(in_item_t))  in_ch ();
  pfc_stream_if #(.T(out_item_t)) out_ch ();

  program_fetch_line_cache_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  fetch_cache_sb sb;
  logic [15:0]   win_base;   // window most fetches of a phase aim at
  bit            src_quiet;  // sender runs without gaps while set

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly no gap, often a short one, now and then a long one
  function automatic int unsigned pick_pause(bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t mk(mode_e m, logic [15:0] pc, logic [15:0] base,
                                  logic [7:0] bank, logic [7:0] d);
    in_item_t it;
    it.mode            = m;
    it.program_counter = pc;
    it.window_base     = base;
    it.code_bank       = bank;
    it.mem_data        = d;
    return it;
  endfunction

  // Next random beat. While a request is open most beats are replies, so
  // line fills run to completion; otherwise most beats are fetches aimed at
  // the phase window with mapped banks, so lines fill up and hits follow.
  // Flushes, stray replies, mode 3 and fully random fetches are the noise.
  function automatic in_item_t next_item();
    in_item_t    it;
    int unsigned r;
    it = mk(MODE_FETCH, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
    r  = $urandom_range(0, 99);
    if (sb.pend != PEND_NONE) begin
      if (r < 90)      it.mode = MODE_REPLY;
      else if (r < 93) it.mode = MODE_FLUSH;
      else if (r < 97) it.mode = MODE_FETCH;   // ignored while busy
      else             it.mode = MODE_NONE;
    end else if (r < 85) begin
      if ($urandom_range(0, 9) != 0) it.window_base = win_base;
      if ($urandom_range(0, 4) != 0)
        it.program_counter = it.window_base + 16'($urandom_range(0, CACHE_B - 1));
      r = $urandom_range(0, 9);
      if (r < 5)      it.code_bank = 8'($urandom_range(0, sb.rom_top));
      else if (r < 8) it.code_bank = r[0] ? RAM_BANK1 : RAM_BANK0;
    end else if (r < 88) begin
      it.mode = MODE_FLUSH;
    end else if (r < 94) begin
      it.mode = MODE_REPLY;                    // nothing pending: ignored
    end else if (r < 97) begin
      it.mode = MODE_NONE;
    end
    return it;
  endfunction

  // One input beat: optional gap, then hold valid until the block takes it.
  // The scoreboard notes the beat at the accepting edge, before the next
  // beat is chosen, so the generator always sees the current pending state.
  task automatic send_beat(input in_item_t it, output bit took);
    int unsigned gap;
    gap = pick_pause(src_quiet);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    took = sb.take_input(it);
  endtask

  // Drop valid, let every due result drain, then allow for beats that leave
  // no result but may still be in flight inside the block.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Both registers in back-to-back cycles; write enable stays high between.
  task automatic program_regs(input logic fast, input logic [7:0] top);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_FAST_CLOCK;
    cfg_data_i <= {7'd0, fast};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MAX_ROM_BANK;
    cfg_data_i <= top;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_regs(fast, top);
  endtask

  // --------------------------------------------------------------------------
  // Output side: random back-pressure, with stretches of none
  // --------------------------------------------------------------------------
  initial begin : sink_side
    int unsigned hold;
    bit          quiet;
    hold  = 0;
    quiet = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 63) == 0) quiet = !quiet;
      if (hold != 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
        hold = pick_pause(quiet);
      end
    end
  end

  // every output beat taken is checked against the oldest due result
  initial begin : result_watch
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    end
  end

  // watchdog: ends the run if no beat moves on either side for too long
  initial begin : stall_watch
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : run
    bit          took;
    int unsigned done_cnt;
    sb        = new();
    src_quiet = 1'b0;
    win_base  = 16'h0000;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_FAST_CLOCK;
    cfg_data_i  <= 8'h00;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    program_regs(1'b0, MAX_ROM_BANK_RST);

    // directed beats, slow clock, ROM up to bank 63
    // reply with nothing pending, then mode 3 with every bit set: both ignored
    send_beat(mk(MODE_REPLY, 16'h0000, 16'h0000, 8'h00, 8'hFF), took);
    send_beat(mk(MODE_NONE, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF), took);
    // unmapped bank inside a window that wraps past 0xFFFF: zero fill of line 0
    send_beat(mk(MODE_FETCH, 16'hFFFF, 16'hFFF0, 8'hFF, 8'h00), took);
    // hit on the zero filled line
    send_beat(mk(MODE_FETCH, 16'hFFF0, 16'hFFF0, 8'hFF, 8'h00), took);
    // unmapped bank outside the window: uncached zero
    send_beat(mk(MODE_FETCH, 16'h1000, 16'h0000, 8'h80, 8'h00), took);
    // ROM bank 0 outside the window: byte read request
    send_beat(mk(MODE_FETCH, 16'hFFFF, 16'h0000, 8'h00, 8'h00), took);
    // fetch while the byte read is open: ignored
    send_beat(mk(MODE_FETCH, 16'h0000, 16'h0000, 8'h3F, 8'h00), took);
    send_beat(mk(MODE_REPLY, 16'h0000, 16'h0000, 8'h00, 8'hA5), took);
    // RAM bank 1, last line of the window: line fill request and a full line
    send_beat(mk(MODE_FETCH, 16'h01FF, 16'h0000, RAM_BANK1, 8'h00), took);
    for (int k = 0; k < LINE_B; k++)
      send_beat(mk(MODE_REPLY, 16'hFFFF, 16'hFFFF, 8'hFF,
                   (k == LINE_B - 1) ? 8'hFF : 8'(k * 17)), took);
    // hit on the filled line
    send_beat(mk(MODE_FETCH, 16'h01F0, 16'h0000, RAM_BANK1, 8'h00), took);
    send_beat(mk(MODE_FLUSH, 16'h0000, 16'h0000, 8'h00, 8'h00), took);
    // line 0 misses again after the flush; a second flush cancels the fill
    send_beat(mk(MODE_FETCH, 16'h0005, 16'hFFFF, 8'h3F, 8'h00), took);
    send_beat(mk(MODE_FLUSH, 16'h0000, 16'h0000, 8'h00, 8'h00), took);
    // first bank above the ROM range that is not RAM: uncached zero
    send_beat(mk(MODE_FETCH, 16'h1234, 16'h1000, 8'h40, 8'h00), took);

    // random phases, one register setting each
    for (int p = 0; p < 6; p++) begin
      settle();
      program_regs(PH_FAST[p], PH_ROM[p * 8 +: 8]);
      win_base = 16'($urandom);
      done_cnt = 0;
      while (done_cnt < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 63) == 0) src_quiet = !src_quiet;
        if ($urandom_range(0, 199) == 0) win_base = 16'($urandom);
        send_beat(next_item(), took);
        if (took) done_cnt++;
      end
    end
    settle();

    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
